FILE: design/cmts_pkg.sv
// Shared types and constants for the cavity mode tune solver.
package cmts_pkg;

  localparam int LEN_W  = 23;
  localparam int CPC_W  = 20;
  localparam int FT_W   = 24;
  localparam int MODE_W = 10;
  localparam int ENC_W  = 28;
  localparam int FREQ_W = 33;
  localparam int IDX_W  = 3;
  localparam int WD_W   = 23;

  // c/2 in MHz*cm, Q16
  localparam logic [29:0] HALF_C_Q16 = 30'd982359926;
  // 0.01 MHz in Q16
  localparam logic [9:0]  TUNE_TOL   = 10'd655;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_HIGH = 2'd1,
    ST_TOO_LOW  = 2'd2,
    ST_NO_MODE  = 2'd3
  } tune_status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_LENGTH    = 3'd0,
    REG_MAX_LENGTH    = 3'd1,
    REG_MIRROR_RADIUS = 3'd2,
    REG_ENC_ZERO_LEN  = 3'd3,
    REG_COUNTS_PER_CM = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    LEN_MIN   = 2'd0,
    LEN_MAX   = 2'd1,
    LEN_GUESS = 2'd2
  } len_sel_t;

  typedef struct packed {
    logic         eval_start;
    len_sel_t     len_sel;
    logic         load;
    logic         m_inc;
    logic         bis_init;
    logic         bis_step;
    logic         keep_best;
    logic         fin_cur;
    logic         fin_err;
    tune_status_t err_code;
    logic         fin_auto;
    logic         enc_calc;
    logic         out_load;
  } cmts_cmd_t;

  typedef struct packed {
    logic auto_mode;
    logic m_over;
    logic f_lt_ft;
    logic f_gt_ft;
    logic near;
    logic iter_last;
    logic worse;
    logic out_free;
  } cmts_flags_t;

endpackage

FILE: design/cmts_if.sv
// Request and result channel interfaces.
interface cmts_req_if;
  logic        valid;
  logic        ready;
  logic [23:0] target_frequency;
  logic        auto_mode;
  logic [9:0]  requested_mode;

  modport source (output valid, target_frequency, auto_mode, requested_mode, input ready);
  modport sink (input valid, target_frequency, auto_mode, requested_mode, output ready);
endinterface

interface cmts_res_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] encoder_position;
  logic [9:0]         chosen_mode;
  logic [1:0]         tune_status;

  modport source (output valid, encoder_position, chosen_mode, tune_status, input ready);
  modport sink (input valid, encoder_position, chosen_mode, tune_status, output ready);
endinterface

FILE: design/cavity_mode_tune_solver_unit.sv
// Top level of the cavity mode tune solver: config registers, controller, datapath.
//
//  channel   dir   beat contents
//  req       in    target_frequency, auto_mode, requested_mode
//  res       out   encoder_position, chosen_mode, tune_status
//  config    in    write_enable, reg_index, write_data
//
// One request at a time. Each frequency evaluation runs from the controller's start
// state to its next decision through a 33-step ratio divide, 24 doubling steps (square,
// then update), the products and their sum, and a 33-step divide.
// A manual request takes 2 + BISECT_STEPS evaluations at most; an auto request
// takes that per candidate mode plus one per mode scanned.
// Reset is synchronous: it restores the register defaults and clears control state.
// A finished result waits in the output register while the next request is taken.
module cavity_mode_tune_solver_unit import cmts_pkg::*; #(
  parameter int MAX_MODE     = 1023,
  parameter int BISECT_STEPS = 32
) (
  input  logic             clk,
  input  logic             rst,
  cmts_req_if.sink         req,
  cmts_res_if.source       res,
  input  logic             write_enable,
  input  logic [IDX_W-1:0] reg_index,
  input  logic [WD_W-1:0]  write_data
);

  localparam int MW_RAW = $clog2(MAX_MODE + 2);
  localparam int MW     = (MW_RAW > MODE_W) ? MW_RAW : MODE_W;

  logic [LEN_W-1:0] min_length;
  logic [LEN_W-1:0] max_length;
  logic [LEN_W-1:0] mirror_radius;
  logic [LEN_W-1:0] encoder_zero_length;
  logic [CPC_W-1:0] counts_per_cm;

  cmts_cmd_t         cmd;
  cmts_flags_t       flags;
  logic              fu_done;
  logic              fu_busy;
  logic [FREQ_W-1:0] freq;
  logic [LEN_W-1:0]  eval_len;
  logic [MW-1:0]     eval_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length          <= 23'd4477551;
      max_length          <= 23'd4777116;
      mirror_radius       <= 23'd5452910;
      encoder_zero_length <= 23'd4647434;
      counts_per_cm       <= 20'd40000;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_MIN_LENGTH:    min_length          <= write_data;
        REG_MAX_LENGTH:    max_length          <= write_data;
        REG_MIRROR_RADIUS: mirror_radius       <= write_data;
        REG_ENC_ZERO_LEN:  encoder_zero_length <= write_data;
        REG_COUNTS_PER_CM: counts_per_cm       <= write_data[CPC_W-1:0];
        default: ;
      endcase
    end
  end

  cmts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .flags     (flags),
    .fu_done   (fu_done),
    .cmd       (cmd)
  );

  cmts_freq_unit #(.MW(MW)) u_freq (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.eval_start),
    .len    (eval_len),
    .mode   (eval_mode),
    .radius (mirror_radius),
    .done   (fu_done),
    .busy   (fu_busy),
    .freq   (freq)
  );

  cmts_dpath #(
    .MAX_MODE     (MAX_MODE),
    .BISECT_STEPS (BISECT_STEPS),
    .MW           (MW)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .flags               (flags),
    .target_frequency    (req.target_frequency),
    .auto_mode           (req.auto_mode),
    .requested_mode      (req.requested_mode),
    .min_length          (min_length),
    .max_length          (max_length),
    .encoder_zero_length (encoder_zero_length),
    .counts_per_cm       (counts_per_cm),
    .freq                (freq),
    .eval_len            (eval_len),
    .eval_mode           (eval_mode),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .encoder_position    (res.encoder_position),
    .chosen_mode         (res.chosen_mode),
    .tune_status         (res.tune_status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a solve is running");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.eval_start |-> !fu_busy)
    else $error("frequency unit started while busy");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.tune_status != ST_OK) |-> (res.encoder_position == '0))
    else $error("nonzero encoder count on an error result");

  a_no_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.tune_status == ST_NO_MODE) |-> (res.chosen_mode == '0))
    else $error("mode reported without a reachable mode");

endmodule

FILE: design/cmts_freq_unit.sv
// Mode frequency unit: shared divider, arccosine doubling loop and products.
module cmts_freq_unit import cmts_pkg::*; #(
  parameter int MW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LEN_W-1:0]  len,
  input  logic [MW-1:0]     mode,
  input  logic [LEN_W-1:0]  radius,
  output logic              done,
  output logic              busy,
  output logic [FREQ_W-1:0] freq
);

  localparam int NW = MW + 31;
  localparam int CW = (NW > LEN_W + 17) ? NW : LEN_W + 17;

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_RDIV = 7'b0000010,
    P_SQ   = 7'b0000100,
    P_UPD  = 7'b0001000,
    P_PROD = 7'b0010000,
    P_SUM  = 7'b0100000,
    P_FDIV = 7'b1000000
  } phase_t;

  phase_t             phase;
  logic [5:0]         cnt;
  logic [LEN_W-1:0]   len_r;
  logic [MW-1:0]      mode_r;
  logic [LEN_W-1:0]   dsr;
  logic [LEN_W-1:0]   rem;
  logic [32:0]        dend;
  logic [32:0]        quo;
  logic               sat;
  logic signed [31:0] c;
  logic               a;
  logic [23:0]        phi;
  logic [60:0]        sq;
  logic [MW+29:0]     qk;
  logic [53:0]        pk;

  logic [LEN_W:0]     t;
  logic               ge;
  logic [LEN_W-1:0]   rem_n;
  logic [32:0]        quo_n;
  logic [31:0]        ratio;
  logic               a_n;
  logic [30:0]        mag;
  logic [32:0]        sh;
  logic [NW-1:0]      n_sum;
  logic [CW-1:0]      n_ext;
  logic [CW-1:0]      len_ext;

  always_comb begin
    t     = {rem, dend[32]};
    ge    = t >= {1'b0, dsr};
    rem_n = ge ? LEN_W'(t - {1'b0, dsr}) : t[LEN_W-1:0];
    quo_n = {quo[31:0], ge};
    if (sat || quo_n > 33'h080000000) begin
      ratio = 32'h80000000;
    end else begin
      ratio = quo_n[31:0];
    end
    a_n     = a ^ c[31];
    mag     = c[31] ? 31'(-c) : 31'(c);
    sh      = 33'((sq + (61'd1 << 28)) >> 29);
    n_sum   = NW'(qk) + NW'((pk + (54'd1 << 23)) >> 24);
    n_ext   = CW'(n_sum);
    len_ext = CW'({len_r, 17'd0});
  end

  assign busy = (phase != P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            len_r  <= len;
            mode_r <= mode;
            dsr    <= radius;
            sat    <= {3'd0, len} >= {radius, 3'd0};
            rem    <= {3'd0, len[LEN_W-1:3]};
            dend   <= {len[2:0], 30'd0};
            quo    <= '0;
            cnt    <= '0;
            phase  <= P_RDIV;
          end
        end
        P_RDIV: begin
          rem  <= rem_n;
          quo  <= quo_n;
          dend <= {dend[31:0], 1'b0};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            c     <= signed'(32'h40000000 - ratio);
            a     <= 1'b0;
            phi   <= '0;
            cnt   <= '0;
            phase <= P_SQ;
          end
        end
        P_SQ: begin
          a     <= a_n;
          phi   <= {phi[22:0], a_n};
          sq    <= 61'(mag * mag);
          phase <= P_UPD;
        end
        P_UPD: begin
          c   <= signed'(32'(sh - 33'h040000000));
          cnt <= cnt + 6'd1;
          phase <= (cnt == 6'd23) ? P_PROD : P_SQ;
        end
        P_PROD: begin
          qk    <= mode_r * HALF_C_Q16;
          pk    <= phi * HALF_C_Q16;
          phase <= P_SUM;
        end
        P_SUM: begin
          if (len_r == '0 || mode_r == '0) begin
            freq  <= '0;
            done  <= 1'b1;
            phase <= P_IDLE;
          end else begin
            sat   <= n_ext >= len_ext;
            rem   <= n_ext[39:17];
            dend  <= {n_ext[16:0], 16'd0};
            dsr   <= len_r;
            quo   <= '0;
            cnt   <= '0;
            phase <= P_FDIV;
          end
        end
        P_FDIV: begin
          rem  <= rem_n;
          quo  <= quo_n;
          dend <= {dend[31:0], 1'b0};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            freq  <= sat ? '1 : quo_n;
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

FILE: design/cmts_dpath.sv
// Datapath: request latch, bisection limits, best mode, encoder result.
module cmts_dpath import cmts_pkg::*; #(
  parameter int MAX_MODE     = 1023,
  parameter int BISECT_STEPS = 32,
  parameter int MW           = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  cmts_cmd_t          cmd,
  output cmts_flags_t        flags,
  input  logic [FT_W-1:0]    target_frequency,
  input  logic               auto_mode,
  input  logic [MODE_W-1:0]  requested_mode,
  input  logic [LEN_W-1:0]   min_length,
  input  logic [LEN_W-1:0]   max_length,
  input  logic [LEN_W-1:0]   encoder_zero_length,
  input  logic [CPC_W-1:0]   counts_per_cm,
  input  logic [FREQ_W-1:0]  freq,
  output logic [LEN_W-1:0]   eval_len,
  output logic [MW-1:0]      eval_mode,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [ENC_W-1:0] encoder_position,
  output logic [MODE_W-1:0]  chosen_mode,
  output logic [1:0]         tune_status
);

  localparam int IW = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;

  logic [31:0]        ft;
  logic               auto_r;
  logic [MW-1:0]      m;
  logic [LEN_W-1:0]   above;
  logic [LEN_W-1:0]   below;
  logic [LEN_W-1:0]   guess;
  logic [IW-1:0]      iter;
  logic [MW-1:0]      best_q;
  logic [LEN_W-1:0]   best_pos;
  logic [LEN_W:0]     best_dist;
  logic               have;
  logic [LEN_W-1:0]   res_pos;
  logic [MW-1:0]      res_q;
  tune_status_t       res_stat;
  logic [42:0]        prod;
  logic               neg;
  logic               ok_r;

  logic [FREQ_W-1:0]  ft_x;
  logic [FREQ_W-1:0]  diff;
  logic [LEN_W:0]     span;
  logic [LEN_W:0]     twice;
  logic [LEN_W:0]     center_gap;
  logic [LEN_W:0]     d;
  logic [LEN_W-1:0]   dmag;
  logic [ENC_W-1:0]   r;
  logic [ENC_W-1:0]   enc;

  always_comb begin
    ft_x  = {1'b0, ft};
    diff  = (freq > ft_x) ? freq - ft_x : ft_x - freq;
    span  = {1'b0, min_length} + {1'b0, max_length};
    twice = {guess, 1'b0};
    center_gap = (twice > span) ? twice - span : span - twice;

    flags.auto_mode = auto_r;
    flags.m_over    = m > MW'(MAX_MODE);
    flags.f_lt_ft   = freq < ft_x;
    flags.f_gt_ft   = freq > ft_x;
    flags.near      = diff <= FREQ_W'(TUNE_TOL);
    flags.iter_last = iter == IW'(BISECT_STEPS - 1);
    flags.worse     = have && (center_gap > best_dist);
    flags.out_free  = !res_valid || res_ready;

    unique case (cmd.len_sel)
      LEN_MIN:   eval_len = min_length;
      LEN_MAX:   eval_len = max_length;
      LEN_GUESS: eval_len = guess;
      default:   eval_len = guess;
    endcase
    eval_mode = m;

    d    = {1'b0, res_pos} - {1'b0, encoder_zero_length};
    dmag = d[LEN_W] ? LEN_W'(-d) : d[LEN_W-1:0];
    r    = ENC_W'((prod + 43'd32768) >> 16);
    if (!ok_r) begin
      enc = '0;
    end else if (neg) begin
      enc = (r > 28'h8000000) ? 28'h8000000 : ENC_W'(-r);
    end else begin
      enc = (r > 28'h7FFFFFF) ? 28'h7FFFFFF : r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ft     <= {target_frequency, 8'd0};
      auto_r <= auto_mode;
      m      <= auto_mode ? MW'(1) : MW'(requested_mode);
      have   <= 1'b0;
    end
    if (cmd.m_inc) begin
      m <= m + MW'(1);
    end
    if (cmd.bis_init) begin
      above <= min_length;
      below <= max_length;
      guess <= LEN_W'(span >> 1);
      iter  <= '0;
    end
    if (cmd.bis_step) begin
      if (flags.f_gt_ft) begin
        above <= guess;
        guess <= LEN_W'(({1'b0, guess} + {1'b0, below}) >> 1);
      end else begin
        below <= guess;
        guess <= LEN_W'(({1'b0, above} + {1'b0, guess}) >> 1);
      end
      iter <= iter + IW'(1);
    end
    if (cmd.keep_best) begin
      best_q    <= m;
      best_pos  <= guess;
      best_dist <= center_gap;
      have      <= 1'b1;
    end
    if (cmd.fin_cur) begin
      res_pos  <= guess;
      res_q    <= m;
      res_stat <= ST_OK;
    end
    if (cmd.fin_err) begin
      res_q    <= m;
      res_stat <= cmd.err_code;
    end
    if (cmd.fin_auto) begin
      if (have) begin
        res_pos  <= best_pos;
        res_q    <= best_q;
        res_stat <= ST_OK;
      end else begin
        res_q    <= '0;
        res_stat <= ST_NO_MODE;
      end
    end
    if (cmd.enc_calc) begin
      prod <= dmag * counts_per_cm;
      neg  <= d[LEN_W];
      ok_r <= (res_stat == ST_OK);
    end
    if (cmd.out_load) begin
      encoder_position <= signed'(enc);
      chosen_mode      <= res_q[MODE_W-1:0];
      tune_status      <= res_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

FILE: design/cmts_ctrl.sv
// Controller: mode scan, span checks, bisection and result sequencing.
module cmts_ctrl import cmts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  cmts_flags_t flags,
  input  logic        fu_done,
  output cmts_cmd_t   cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SCAN_EV  = 15'b000000000000010,
    S_SCAN_WT  = 15'b000000000000100,
    S_LOOP_EV  = 15'b000000000001000,
    S_LOOP_WT  = 15'b000000000010000,
    S_CHKHI_EV = 15'b000000000100000,
    S_CHKHI_WT = 15'b000000001000000,
    S_CHKLO_EV = 15'b000000010000000,
    S_CHKLO_WT = 15'b000000100000000,
    S_BIS_EV   = 15'b000001000000000,
    S_BIS_WT   = 15'b000010000000000,
    S_SOLVED   = 15'b000100000000000,
    S_FIN      = 15'b001000000000000,
    S_ENC      = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.len_sel  = LEN_GUESS;
    cmd.err_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHKHI_EV;
        end
      end
      S_SCAN_EV: begin
        if (flags.m_over) begin
          state_next = S_FIN;
        end else begin
          cmd.eval_start = 1'b1;
          cmd.len_sel    = LEN_MIN;
          state_next     = S_SCAN_WT;
        end
      end
      S_SCAN_WT: begin
        if (fu_done) begin
          if (!flags.f_gt_ft) begin
            cmd.m_inc  = 1'b1;
            state_next = S_SCAN_EV;
          end else begin
            state_next = S_LOOP_EV;
          end
        end
      end
      S_LOOP_EV: begin
        if (flags.m_over) begin
          state_next = S_FIN;
        end else begin
          cmd.eval_start = 1'b1;
          cmd.len_sel    = LEN_MAX;
          state_next     = S_LOOP_WT;
        end
      end
      S_LOOP_WT: begin
        // below the target at the long end: the short-end check settles the rest
        if (fu_done) begin
          state_next = flags.f_lt_ft ? S_CHKLO_EV : S_FIN;
        end
      end
      S_CHKHI_EV: begin
        // the first pass after a load comes here; auto requests branch off to the scan
        if (flags.auto_mode) begin
          state_next = S_SCAN_EV;
        end else begin
          cmd.eval_start = 1'b1;
          cmd.len_sel    = LEN_MAX;
          state_next     = S_CHKHI_WT;
        end
      end
      S_CHKHI_WT: begin
        if (fu_done) begin
          if (flags.f_gt_ft) begin
            cmd.fin_err  = 1'b1;
            cmd.err_code = ST_TOO_HIGH;
            state_next   = S_ENC;
          end else begin
            state_next = S_CHKLO_EV;
          end
        end
      end
      S_CHKLO_EV: begin
        cmd.eval_start = 1'b1;
        cmd.len_sel    = LEN_MIN;
        state_next     = S_CHKLO_WT;
      end
      S_CHKLO_WT: begin
        if (fu_done) begin
          if (flags.f_lt_ft) begin
            if (flags.auto_mode) begin
              state_next = S_FIN;
            end else begin
              cmd.fin_err  = 1'b1;
              cmd.err_code = ST_TOO_LOW;
              state_next   = S_ENC;
            end
          end else begin
            cmd.bis_init = 1'b1;
            state_next   = S_BIS_EV;
          end
        end
      end
      S_BIS_EV: begin
        cmd.eval_start = 1'b1;
        cmd.len_sel    = LEN_GUESS;
        state_next     = S_BIS_WT;
      end
      S_BIS_WT: begin
        if (fu_done) begin
          if (flags.near) begin
            state_next = S_SOLVED;
          end else begin
            cmd.bis_step = 1'b1;
            state_next   = flags.iter_last ? S_SOLVED : S_BIS_EV;
          end
        end
      end
      S_SOLVED: begin
        if (!flags.auto_mode) begin
          cmd.fin_cur = 1'b1;
          state_next  = S_ENC;
        end else if (flags.worse) begin
          state_next = S_FIN;
        end else begin
          cmd.keep_best = 1'b1;
          cmd.m_inc     = 1'b1;
          state_next    = S_LOOP_EV;
        end
      end
      S_FIN: begin
        cmd.fin_auto = 1'b1;
        state_next   = S_ENC;
      end
      S_ENC: begin
        cmd.enc_calc = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
